// ===== rtl/ctd_pkg.sv =====
// ----------------------------------------------------------------------------
// ctd_pkg
// Types, codes and helpers shared by the chunked transfer decoder modules.
// ----------------------------------------------------------------------------
package ctd_pkg;

  localparam int MAX_DIGITS  = 8;
  localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int COUNT_W     = 32;
  localparam int HEX_W       = 4;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [3:0] {
    ST_START   = 4'd0,
    ST_SIZE    = 4'd1,
    ST_SIZE_CR = 4'd2,
    ST_SIZE_LF = 4'd3,
    ST_DATA    = 4'd4,
    ST_DATA_CR = 4'd5,
    ST_DATA_LF = 4'd6,
    ST_END_CR  = 4'd7,
    ST_END     = 4'd8,
    ST_ERROR   = 4'd9
  } parse_state_t;

  typedef enum logic [2:0] {
    CL_DIGIT = 3'd0,
    CL_CR    = 3'd1,
    CL_LF    = 3'd2,
    CL_DATA  = 3'd3,
    CL_BAD   = 3'd4
  } byte_class_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_WANT_DIGIT  = 3'd1,
    ERR_WANT_CR     = 3'd2,
    ERR_WANT_LF     = 3'd3,
    ERR_WANT_CR_DIG = 3'd4,
    ERR_FINISHED    = 3'd5,
    ERR_SIZE_LONG   = 3'd6,
    ERR_STICKY      = 3'd7
  } err_code_t;

  typedef struct packed {
    byte_class_t byte_class;
    logic [7:0]  byte_echo;
    logic        is_error;
    err_code_t   error_code;
    logic        finished;
  } ctd_result_t;

  function automatic logic hex_valid(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
           (b >= "A" && b <= "F");
  endfunction

  function automatic logic [HEX_W-1:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    if (b >= "0" && b <= "9") begin
      v = b - 8'h30;
    end else if (b >= "a" && b <= "f") begin
      v = b - 8'h57;
    end else begin
      v = b - 8'h37;
    end
    return v[HEX_W-1:0];
  endfunction

endpackage

// ===== rtl/chunked_transfer_decoder.sv =====
// ----------------------------------------------------------------------------
// chunked_transfer_decoder
// Checks the framing of a chunked body one byte per word, one result each.
// ----------------------------------------------------------------------------
// path: input register, parser, result register; one byte per cycle unless
//   results stall; the input register feeds the parser, which updates its
//   state in the same cycle the result register loads
// reset clears both valid flags and returns the parser to payload start
// start_new on a word restarts parsing before that byte is handled
module chunked_transfer_decoder
  import ctd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] start_new
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] byte_echo, [8] is_error,
                                 // [11:9] error_code, [12] finished
  output logic [2:0]  m_tuser    // [2:0] byte_class
);

  logic        in_valid;
  logic [7:0]  in_byte_q;
  logic        in_start_q;
  logic        step;
  ctd_result_t res, res_q;

  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte_q  <= s_tdata;
      in_start_q <= s_tuser;
    end
  end

  ctd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_byte   (in_byte_q),
    .start_new (in_start_q),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_tdata = {3'b000, res_q.finished, res_q.error_code, res_q.is_error,
                    res_q.byte_echo};
  assign m_tuser = res_q.byte_class;

endmodule

// ===== rtl/ctd_parser.sv =====
// ----------------------------------------------------------------------------
// ctd_parser
// Framing state, size down-counter and per-word classification.
// ----------------------------------------------------------------------------
module ctd_parser
  import ctd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  in_byte,
  input  logic        start_new,
  output ctd_result_t res
);

  parse_state_t            state, state_next;
  logic [COUNT_W-1:0]      remaining, remaining_next;
  logic [DIGIT_CNT_W-1:0]  digit_count, digit_count_next;

  parse_state_t            cur_state;
  logic [COUNT_W-1:0]      cur_rem;
  logic [DIGIT_CNT_W-1:0]  cur_dc;
  logic [COUNT_W-1:0]      acc_base;
  logic [DIGIT_CNT_W-1:0]  dc_base;
  logic                    is_hex;
  logic [HEX_W-1:0]        hv;
  logic                    digit_ovf;
  byte_class_t             cls;
  err_code_t               err;
  logic                    new_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_START;
      remaining   <= '0;
      digit_count <= '0;
    end else if (step) begin
      state       <= state_next;
      remaining   <= remaining_next;
      digit_count <= digit_count_next;
    end
  end

  always_comb begin
    cur_state = start_new ? ST_START : state;
    cur_rem   = start_new ? '0 : remaining;
    cur_dc    = start_new ? '0 : digit_count;
    is_hex    = hex_valid(in_byte);
    hv        = hex_value(in_byte);
    new_line  = (cur_state == ST_START) || (cur_state == ST_DATA_LF);
    // a new size line restarts the accumulator
    acc_base  = new_line ? '0 : cur_rem;
    dc_base   = new_line ? '0 : cur_dc;
    digit_ovf = (dc_base >= DIGIT_CNT_W'(MAX_DIGITS)) ||
                (acc_base[COUNT_W-1 -: HEX_W] != '0);

    state_next       = cur_state;
    remaining_next   = cur_rem;
    digit_count_next = cur_dc;
    cls              = CL_BAD;
    err              = ERR_NONE;

    unique case (cur_state)
      ST_START, ST_DATA_LF: begin
        if (is_hex) begin
          cls        = CL_DIGIT;
          state_next = ST_SIZE;
          if (digit_ovf) begin
            err = ERR_SIZE_LONG;
          end else begin
            remaining_next   = {acc_base[COUNT_W-HEX_W-1:0], hv};
            digit_count_next = dc_base + 1'b1;
          end
        end else begin
          err = ERR_WANT_DIGIT;
        end
      end
      ST_SIZE: begin
        if (is_hex) begin
          cls = CL_DIGIT;
          if (digit_ovf) begin
            err = ERR_SIZE_LONG;
          end else begin
            remaining_next   = {acc_base[COUNT_W-HEX_W-1:0], hv};
            digit_count_next = dc_base + 1'b1;
          end
        end else if (in_byte == CH_CR) begin
          cls        = CL_CR;
          state_next = ST_SIZE_CR;
        end else begin
          err = ERR_WANT_CR_DIG;
        end
      end
      ST_SIZE_CR: begin
        if (in_byte == CH_LF) begin
          cls        = CL_LF;
          state_next = ST_SIZE_LF;
        end else begin
          err = ERR_WANT_LF;
        end
      end
      ST_SIZE_LF: begin
        if (cur_rem == '0) begin
          if (in_byte == CH_CR) begin
            cls        = CL_CR;
            state_next = ST_END_CR;
          end else begin
            err = ERR_WANT_CR;
          end
        end else begin
          remaining_next = cur_rem - 1'b1;
          cls            = CL_DATA;
          state_next     = ST_DATA;
        end
      end
      ST_DATA: begin
        if (cur_rem != '0) begin
          remaining_next = cur_rem - 1'b1;
          cls            = CL_DATA;
        end else if (in_byte == CH_CR) begin
          cls        = CL_CR;
          state_next = ST_DATA_CR;
        end else begin
          err = ERR_WANT_CR;
        end
      end
      ST_DATA_CR: begin
        if (in_byte == CH_LF) begin
          cls        = CL_LF;
          state_next = ST_DATA_LF;
        end else begin
          err = ERR_WANT_LF;
        end
      end
      ST_END_CR: begin
        if (in_byte == CH_LF) begin
          cls        = CL_LF;
          state_next = ST_END;
        end else begin
          err = ERR_WANT_LF;
        end
      end
      ST_END: begin
        err = ERR_FINISHED;
      end
      default: begin
        // error state and unused codes
        err = ERR_STICKY;
      end
    endcase

    if (err != ERR_NONE) begin
      cls        = CL_BAD;
      state_next = ST_ERROR;
    end

    res.byte_class = cls;
    res.byte_echo  = in_byte;
    res.is_error   = (state_next == ST_ERROR);
    res.error_code = err;
    res.finished   = (state_next == ST_END);
  end

  a_err_is_bad: assert property (@(posedge clk) disable iff (rst)
    step && res.error_code != ERR_NONE |-> res.byte_class == CL_BAD && res.is_error)
    else $error("error word not classed as invalid");

  a_finish_state: assert property (@(posedge clk) disable iff (rst)
    step && res.finished |=> state == ST_END)
    else $error("finished reported without end state");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    step && !start_new && state == ST_ERROR |=> state == ST_ERROR)
    else $error("left error state without restart");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= DIGIT_CNT_W'(MAX_DIGITS))
    else $error("digit count beyond limit");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(state) && $stable(remaining))
    else $error("parser state moved without a word");

endmodule

// ===== verif/ctd_checker.sv =====
// ----------------------------------------------------------------------------
// ctd_checker
// Watches both stream sides of the chunked transfer decoder. It runs its own
// copy of the framing parser on every accepted input word, queues the
// predicted result and compares each accepted result word field by field.
// ----------------------------------------------------------------------------
module ctd_checker
  import ctd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic [2:0]  m_tuser,
  output int          mismatches,
  output int          pending
);

  parse_state_t st;
  logic [31:0]  remaining;
  logic [4:0]   digits;
  err_code_t    first_err;
  ctd_result_t  decoded_q[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch on %0s: got %0h, want %0h (%0d words queued)", what, got, want,
             decoded_q.size());
    mismatches++;
  endtask

  function automatic err_code_t append_digit(input logic [3:0] nib);
    if (digits >= MAX_DIGITS || remaining[31:28] != 4'h0) begin
      return ERR_SIZE_LONG;
    end
    remaining = {remaining[27:0], nib};
    digits    = digits + 5'd1;
    return ERR_NONE;
  endfunction

  function automatic ctd_result_t decode_byte(input logic [7:0] b, input logic restart);
    ctd_result_t r;
    byte_class_t cls;
    err_code_t   err;
    logic        is_hex;
    logic [3:0]  nib;
    cls = CL_BAD;
    err = ERR_NONE;
    if (restart) begin
      st        = ST_START;
      remaining = '0;
      digits    = '0;
      first_err = ERR_NONE;
    end
    is_hex = 1'b1;
    nib    = b[3:0];
    if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
      nib = b[3:0] + 4'd9;
    end else if (!(b >= "0" && b <= "9")) begin
      is_hex = 1'b0;
    end
    case (st)
      ST_START, ST_DATA_LF: begin
        if (is_hex) begin
          // a new size line starts from a clean count
          remaining = '0;
          digits    = '0;
          err       = append_digit(nib);
          cls       = CL_DIGIT;
          st        = ST_SIZE;
        end else begin
          err = ERR_WANT_DIGIT;
        end
      end
      ST_SIZE: begin
        if (is_hex) begin
          err = append_digit(nib);
          cls = CL_DIGIT;
        end else if (b == CH_CR) begin
          cls = CL_CR;
          st  = ST_SIZE_CR;
        end else begin
          err = ERR_WANT_CR_DIG;
        end
      end
      ST_SIZE_CR: begin
        if (b == CH_LF) begin
          cls = CL_LF;
          st  = ST_SIZE_LF;
        end else begin
          err = ERR_WANT_LF;
        end
      end
      ST_SIZE_LF: begin
        if (remaining == '0) begin
          if (b == CH_CR) begin
            cls = CL_CR;
            st  = ST_END_CR;
          end else begin
            err = ERR_WANT_CR;
          end
        end else begin
          remaining = remaining - 32'd1;
          cls       = CL_DATA;
          st        = ST_DATA;
        end
      end
      ST_DATA: begin
        if (remaining != '0) begin
          remaining = remaining - 32'd1;
          cls       = CL_DATA;
        end else if (b == CH_CR) begin
          cls = CL_CR;
          st  = ST_DATA_CR;
        end else begin
          err = ERR_WANT_CR;
        end
      end
      ST_DATA_CR: begin
        if (b == CH_LF) begin
          cls = CL_LF;
          st  = ST_DATA_LF;
        end else begin
          err = ERR_WANT_LF;
        end
      end
      ST_END_CR: begin
        if (b == CH_LF) begin
          cls = CL_LF;
          st  = ST_END;
        end else begin
          err = ERR_WANT_LF;
        end
      end
      ST_END: begin
        err = ERR_FINISHED;
      end
      default: begin
        err = ERR_STICKY;
      end
    endcase
    if (err != ERR_NONE) begin
      cls = CL_BAD;
      if (st != ST_ERROR && first_err == ERR_NONE) first_err = err;
      if (first_err == ERR_NONE) first_err = ERR_STICKY;
      st = ST_ERROR;
    end
    r.byte_class = cls;
    r.byte_echo  = b;
    r.is_error   = (st == ST_ERROR);
    r.error_code = err;
    r.finished   = (st == ST_END);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    ctd_result_t want;
    if (rst) begin
      st        = ST_START;
      remaining = '0;
      digits    = '0;
      first_err = ERR_NONE;
      decoded_q.delete();
    end else begin
      // results first, so a word accepted at this edge cannot meet itself
      if (m_tvalid && m_tready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result word", m_tdata, '0);
        end else begin
          want = decoded_q.pop_front();
          if (m_tuser !== want.byte_class)
            report_mismatch("byte_class", m_tuser, want.byte_class);
          if (m_tdata[7:0] !== want.byte_echo)
            report_mismatch("byte_echo", m_tdata[7:0], want.byte_echo);
          if (m_tdata[8] !== want.is_error)
            report_mismatch("is_error", m_tdata[8], want.is_error);
          if (m_tdata[11:9] !== want.error_code)
            report_mismatch("error_code", m_tdata[11:9], want.error_code);
          if (m_tdata[12] !== want.finished)
            report_mismatch("finished", m_tdata[12], want.finished);
          if (m_tdata[15:13] !== 3'b000)
            report_mismatch("tdata padding", m_tdata[15:13], '0);
        end
      end
      if (s_tvalid && s_tready) begin
        decoded_q.push_back(decode_byte(s_tdata, s_tuser));
      end
    end
    pending = decoded_q.size();
  end

endmodule

// ===== verif/tb_chunked_transfer_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_chunked_transfer_decoder
// Feeds the decoder a few hand-picked framing faults, then randomly built
// chunked bodies (some broken) mixed with noise, with random gaps on both
// sides, a long result back-pressure and a full drain. ctd_checker predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module tb_chunked_transfer_decoder;
  import ctd_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  int          mismatches;
  int          pending;

  bit          source_gaps = 1'b1;
  bit          sink_gaps   = 1'b1;
  bit          hold_sink   = 1'b0;
  int          sent        = 0;
  logic [7:0]  frame_q[$];

  chunked_transfer_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ctd_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("FAIL chunked_transfer_decoder");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : sink
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_sink = 1'b0;
      end
      m_tready <= !sink_gaps || ($urandom_range(99) >= 13);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic sn);
    while (source_gaps && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= sn;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // first character restarts the parser
  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_word(txt[i], i == 0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  task automatic add_size_line(input int unsigned size);
    int nd;
    int zeros;
    nd = 1;
    while (nd < 8 && (size >> (4 * nd)) != 0) nd++;
    zeros = ($urandom_range(3) == 0) ? $urandom_range(8 - nd) : 0;
    repeat (zeros) frame_q.push_back("0");
    for (int i = nd - 1; i >= 0; i--) frame_q.push_back(hex_char(4'(size >> (4 * i))));
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
  endtask

  // one chunked body with random content, about a third of them broken
  task automatic send_body();
    int  size;
    int  cut;
    int  restart_at;
    bit  first_sn;
    frame_q.delete();
    repeat ($urandom_range(3)) begin
      size = ($urandom_range(7) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
      add_size_line(size);
      repeat (size) frame_q.push_back(8'($urandom_range(255)));
      frame_q.push_back(CH_CR);
      frame_q.push_back(CH_LF);
    end
    add_size_line(0);
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
    restart_at = -1;
    if ($urandom_range(99) < 30) begin
      cut = $urandom_range(frame_q.size() - 1);
      case ($urandom_range(4))
        0: frame_q[cut] = 8'($urandom_range(255));
        1: frame_q = frame_q[0:cut];
        2: repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(255)));
        3: restart_at = cut;
        default: repeat (9) frame_q.push_front("0");
      endcase
    end
    first_sn = ($urandom_range(9) != 0);
    foreach (frame_q[i]) send_word(frame_q[i], (i == 0) ? first_sn : (i == restart_at));
  endtask

  initial begin : stimulus
    bit stalled;
    bit drained;
    stalled = 1'b0;
    drained = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("0\r\n\r\n");       // empty body, finishes
    send_word("z", 1'b0);         // byte after finish
    send_word(8'h00, 1'b0);       // sticky error
    send_text("ffffffffF");       // ninth size digit is too long
    send_text("1x");              // want cr or digit
    send_text("2\r");
    send_word(8'hFF, 1'b0);       // missing lf
    send_text("0\r\nA");          // missing cr after zero-size line
    send_text("1\r\n");
    send_word(8'h80, 1'b0);
    send_word("A", 1'b0);         // missing cr after data run
    send_text("G");               // want digit

    while (sent < 1130) begin
      source_gaps = !(sent >= 400 && sent < 600);
      sink_gaps   = source_gaps;
      if (!stalled && sent > 250) begin
        hold_sink = 1'b1;
        stalled   = 1'b1;
      end
      if (!drained && sent > 750) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        drained = 1'b1;
      end
      if ($urandom_range(3) != 0) begin
        send_body();
      end else begin
        repeat ($urandom_range(1, 8))
          send_word(8'($urandom_range(255)), $urandom_range(9) == 0);
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS chunked_transfer_decoder");
    end else begin
      $display("FAIL chunked_transfer_decoder");
    end
    $finish;
  end

endmodule
